// ===== hw/rtl/lobm_pkg.sv =====
package lobm_pkg;
  localparam int BookDepth = 16;
  localparam int IdxW = $clog2(BookDepth);
  localparam int CntW = $clog2(BookDepth + 1);

  typedef enum logic [1:0] {
    KIND_BUY   = 2'd0,
    KIND_SELL  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_FILLED  = 2'd0,
    ST_RESTED  = 2'd1,
    ST_DROPPED = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] price;
    logic [31:0] id;
    logic [30:0] rem;
    logic [30:0] orig;
  } entry_t;

  // commands from the sequencer to one book
  typedef struct packed {
    logic   clear;
    logic   pop;
    logic   upd_head;
    logic   insert;
    logic [30:0] head_rem;
    entry_t ins;
  } book_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    entry_t          head;
    logic [IdxW-1:0] ins_pos;
  } book_sts_t;
endpackage

// ===== hw/rtl/lobm_book.sv =====
module lobm_book (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               is_bid,
  input  lobm_pkg::book_cmd_t cmd,
  output lobm_pkg::book_sts_t sts
);
  import lobm_pkg::*;

  entry_t          ent_r [BookDepth];
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic [BookDepth-1:0] after;
  logic [IdxW-1:0] ins_pos;

  // an entry lies behind the new one if it does not beat or tie its price
  always_comb begin
    for (int i = 0; i < BookDepth; i++) begin
      if (CntW'(i) >= count_r) after[i] = 1'b1;
      else if (is_bid) after[i] = ent_r[i].price < cmd.ins.price;
      else after[i] = ent_r[i].price > cmd.ins.price;
    end
  end

  always_comb begin
    ins_pos = IdxW'(BookDepth - 1);
    for (int i = BookDepth - 1; i >= 0; i--)
      if (after[i]) ins_pos = IdxW'(i);
  end

  assign sts = {count_r, ent_r[0], ins_pos};

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) count_nxt = '0;
    else if (cmd.pop) count_nxt = count_r - 1'b1;
    else if (cmd.insert) count_nxt = count_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else count_r <= count_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      for (int i = 0; i < BookDepth - 1; i++) ent_r[i] <= ent_r[i + 1];
    end else if (cmd.upd_head) begin
      ent_r[0].rem <= cmd.head_rem;
    end else if (cmd.insert) begin
      for (int i = 0; i < BookDepth; i++) begin
        if (IdxW'(i) == ins_pos) ent_r[i] <= cmd.ins;
        else if (after[i] && i > 0) ent_r[i] <= ent_r[i - 1];
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> count_r < CntW'(BookDepth)) else $error("book overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> count_r != '0) else $error("book underflow");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> count_r == '0) else $error("clear failed");
`endif
endmodule

// ===== hw/rtl/limit_order_book_matcher.sv =====
// Limit order book matcher.
// Input channel in_*: kind (buy, sell, clear), order_id, price, amount.
// Result channel out_*: one trade record per match, then one closing record
// with last set that gives the order's status.
// Both channels transfer when valid is high and stall is low.
// Each input is accepted, then matched against the book head once per trade
// (the shared compare/subtract unit against the book head); a step finds that
// no further match is possible and the closing record follows; a resting
// remainder is inserted with a shift in the same cycle the closing record is
// loaded. A clear goes straight to its closing record; an unused kind gives no
// record. Steps that load a result wait while the receiver stalls.
// in_stall is high while an item is at work; each result waits in the
// output register until taken, and matching waits for it.
// Reset empties both books; book contents are undefined until written.
module limit_order_book_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_order_id,
  input  logic [31:0] in_price,
  input  logic [30:0] in_amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_type,
  output logic [31:0] out_buy_id,
  output logic [31:0] out_sell_id,
  output logic [30:0] out_trade_amount,
  output logic [31:0] out_trade_price,
  output logic [30:0] out_buy_original,
  output logic [30:0] out_sell_original,
  output logic [1:0]  out_status,
  output logic        out_last
);
  import lobm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_CLOSE} state_t;

  state_t      state_r;
  logic [1:0]  kind_r;
  logic [31:0] id_r;
  logic [31:0] price_r;
  logic [30:0] amt_r;
  logic [30:0] left_r;

  book_cmd_t bid_cmd, ask_cmd;
  book_sts_t bid_sts, ask_sts;

  lobm_book u_bid (.clk, .rst_n, .is_bid(1'b1), .cmd(bid_cmd), .sts(bid_sts));
  lobm_book u_ask (.clk, .rst_n, .is_bid(1'b0), .cmd(ask_cmd), .sts(ask_sts));

  logic      is_buy;
  book_sts_t opp;
  book_sts_t own;
  logic      can_match;
  logic [30:0] t_amt;
  logic      out_free;
  logic      head_done;
  logic      load_out;

  assign is_buy = kind_r == KIND_BUY;
  assign opp = is_buy ? ask_sts : bid_sts;
  assign own = is_buy ? bid_sts : ask_sts;
  assign can_match = opp.count != '0 && left_r != '0 &&
                     (is_buy ? price_r >= opp.head.price : price_r <= opp.head.price);
  // shared unit: min and subtract of the two remaining amounts
  assign t_amt = left_r < opp.head.rem ? left_r : opp.head.rem;
  assign head_done = t_amt == opp.head.rem;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = state_r != S_IDLE;
  assign load_out = out_free && ((state_r == S_MATCH && can_match) || state_r == S_CLOSE);

  always_comb begin
    book_cmd_t mc, ic;
    mc = '0;
    ic = '0;
    ic.ins.price = price_r;
    ic.ins.id    = id_r;
    ic.ins.rem   = left_r;
    ic.ins.orig  = amt_r;
    if (state_r == S_MATCH && out_free && can_match) begin
      mc.pop      = head_done;
      mc.upd_head = !head_done;
      mc.head_rem = opp.head.rem - t_amt;
    end
    if (state_r == S_CLOSE && out_free && left_r != '0 &&
        own.count < CntW'(BookDepth))
      ic.insert = 1'b1;
    bid_cmd = is_buy ? ic : mc;
    ask_cmd = is_buy ? mc : ic;
    if (state_r == S_CLOSE && kind_r == KIND_CLEAR) begin
      bid_cmd = '0;
      ask_cmd = '0;
      bid_cmd.clear = 1'b1;
      ask_cmd.clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= in_kind;
            id_r    <= in_order_id;
            price_r <= in_price;
            amt_r   <= in_amount;
            left_r  <= in_amount;
            if (in_kind == KIND_CLEAR) state_r <= S_CLOSE;
            else if (in_kind != KIND_NONE) state_r <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (out_free) begin
            if (can_match) begin
              left_r            <= left_r - t_amt;
              out_record_type   <= 1'b0;
              out_buy_id        <= is_buy ? id_r : opp.head.id;
              out_sell_id       <= is_buy ? opp.head.id : id_r;
              out_trade_amount  <= t_amt;
              out_trade_price   <= is_buy ? opp.head.price : price_r;
              out_buy_original  <= is_buy ? amt_r : opp.head.orig;
              out_sell_original <= is_buy ? opp.head.orig : amt_r;
              out_status        <= ST_FILLED;
              out_last          <= 1'b0;
            end else begin
              state_r <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          if (out_free) begin
            state_r         <= S_IDLE;
            out_record_type <= 1'b1;
            out_last        <= 1'b1;
            if (kind_r == KIND_CLEAR) begin
              out_buy_id        <= '0;
              out_sell_id       <= '0;
              out_trade_amount  <= '0;
              out_trade_price   <= '0;
              out_buy_original  <= '0;
              out_sell_original <= '0;
              out_status        <= ST_CLEARED;
            end else begin
              out_buy_id        <= is_buy ? id_r : '0;
              out_sell_id       <= is_buy ? '0 : id_r;
              out_trade_amount  <= left_r;
              out_trade_price   <= price_r;
              out_buy_original  <= is_buy ? amt_r : '0;
              out_sell_original <= is_buy ? '0 : amt_r;
              if (left_r == '0) out_status <= ST_FILLED;
              else if (own.count >= CntW'(BookDepth)) out_status <= ST_DROPPED;
              else out_status <= ST_RESTED;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_trade_amount))
    else $error("result dropped while stalled");
  a_last_closing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last == out_record_type) else $error("last mismatch");
  a_trade_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_record_type |-> out_trade_amount != '0)
    else $error("empty trade");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("accepted while busy");
`endif
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;

  localparam int Depth = BookDepth;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] order_id;
    logic [31:0] price;
    logic [30:0] amount;
  } order_t;

  typedef struct packed {
    logic        record_type;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [30:0] trade_amount;
    logic [31:0] trade_price;
    logic [30:0] buy_original;
    logic [30:0] sell_original;
    logic [1:0]  status;
    logic        last;
  } record_t;

  typedef struct {
    logic [31:0] price;
    logic [31:0] id;
    logic [30:0] rem;
    logic [30:0] orig;
  } rest_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [31:0] in_order_id = '0;
  logic [31:0] in_price = '0;
  logic [30:0] in_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_record_type;
  logic [31:0] out_buy_id, out_sell_id, out_trade_price;
  logic [30:0] out_trade_amount, out_buy_original, out_sell_original;
  logic [1:0] out_status;
  logic out_last;

  limit_order_book_matcher u_dut (.*);

  order_t  pending_orders[$];
  record_t expected_records[$];
  rest_t   bids[$];
  rest_t   asks[$];
  int      errors = 0;
  bit      quiet = 0;        // no idling on either side
  bit      hold_sender = 0;  // sender waits for the result queue to drain
  bit      stim_done = 0;
  int      idle_cycles = 0;

  initial forever #5 clk = ~clk;

  function automatic record_t mk_rec(logic rt, logic [31:0] b, logic [31:0] s,
                                     logic [30:0] a, logic [31:0] p,
                                     logic [30:0] bo, logic [30:0] so,
                                     logic [1:0] st);
    record_t r;
    r = '{rt, b, s, a, p, bo, so, st, rt};
    return r;
  endfunction

  function automatic void expect_rec(record_t r);
    expected_records = {expected_records, r};
  endfunction

  function automatic void queue_order(order_t o);
    pending_orders = {pending_orders, o};
  endfunction

  // book model: trades then the closing record (only that for a clear, none for an unused kind)
  task automatic match_order(input order_t o);
    logic [30:0] left, t;
    rest_t e;
    int pos;
    status_t st;
    left = o.amount;
    if (o.kind == KIND_CLEAR) begin
      bids.delete();
      asks.delete();
      expect_rec(mk_rec(1'b1, '0, '0, '0, '0, '0, '0, ST_CLEARED));
      return;
    end
    if (o.kind == KIND_NONE) return;
    if (o.kind == KIND_BUY) begin
      while (asks.size() > 0 && left > 0 && o.price >= asks[0].price) begin
        t = (left < asks[0].rem) ? left : asks[0].rem;
        expect_rec(mk_rec(1'b0, o.order_id, asks[0].id, t, asks[0].price,
                          o.amount, asks[0].orig, ST_FILLED));
        left -= t;
        asks[0].rem -= t;
        if (asks[0].rem == 0) asks.delete(0);
      end
    end else begin
      while (bids.size() > 0 && left > 0 && o.price <= bids[0].price) begin
        t = (left < bids[0].rem) ? left : bids[0].rem;
        expect_rec(mk_rec(1'b0, bids[0].id, o.order_id, t, o.price,
                          bids[0].orig, o.amount, ST_FILLED));
        left -= t;
        bids[0].rem -= t;
        if (bids[0].rem == 0) bids.delete(0);
      end
    end
    e = '{o.price, o.order_id, left, o.amount};
    if (left == 0) st = ST_FILLED;
    else if (o.kind == KIND_BUY) begin
      if (bids.size() >= Depth) st = ST_DROPPED;
      else begin
        pos = 0;
        while (pos < bids.size() && bids[pos].price >= o.price) pos++;
        bids.insert(pos, e);
        st = ST_RESTED;
      end
    end else begin
      if (asks.size() >= Depth) st = ST_DROPPED;
      else begin
        pos = 0;
        while (pos < asks.size() && asks[pos].price <= o.price) pos++;
        asks.insert(pos, e);
        st = ST_RESTED;
      end
    end
    if (o.kind == KIND_BUY)
      expect_rec(mk_rec(1'b1, o.order_id, '0, left, o.price, o.amount, '0, st));
    else
      expect_rec(mk_rec(1'b1, '0, o.order_id, left, o.price, '0, o.amount, st));
  endtask

  function automatic order_t mk_order(logic [1:0] k, logic [31:0] id, logic [31:0] p,
                                      logic [30:0] a);
    order_t o;
    o = '{k, id, p, a};
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        match_order('{in_kind, in_order_id, in_price, in_amount});
        pending_orders.delete(0);
      end
      if (in_valid && in_stall) begin
        // hold payload while stalled
      end else if (pending_orders.size() > 0 && !hold_sender
                   && (quiet || $urandom_range(99) >= 12)) begin
        in_valid <= 1'b1;
        {in_kind, in_order_id, in_price, in_amount} <= pending_orders[0];
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= !quiet && ($urandom_range(99) < 12);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    record_t got, exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLimit) begin
        $display("Some tests failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = '{out_record_type, out_buy_id, out_sell_id, out_trade_amount,
                out_trade_price, out_buy_original, out_sell_original, out_status,
                out_last};
        if (expected_records.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          exp_r = expected_records[0];
          expected_records.delete(0);
          if (got.record_type !== exp_r.record_type) begin
            $error("record_type exp %0h got %0h", exp_r.record_type, got.record_type); errors++; end
          if (got.buy_id !== exp_r.buy_id) begin
            $error("buy_id exp %0h got %0h", exp_r.buy_id, got.buy_id); errors++; end
          if (got.sell_id !== exp_r.sell_id) begin
            $error("sell_id exp %0h got %0h", exp_r.sell_id, got.sell_id); errors++; end
          if (got.trade_amount !== exp_r.trade_amount) begin
            $error("trade_amount exp %0h got %0h", exp_r.trade_amount, got.trade_amount);
            errors++; end
          if (got.trade_price !== exp_r.trade_price) begin
            $error("trade_price exp %0h got %0h", exp_r.trade_price, got.trade_price);
            errors++; end
          if (got.buy_original !== exp_r.buy_original) begin
            $error("buy_original exp %0h got %0h", exp_r.buy_original, got.buy_original);
            errors++; end
          if (got.sell_original !== exp_r.sell_original) begin
            $error("sell_original exp %0h got %0h", exp_r.sell_original, got.sell_original);
            errors++; end
          if (got.status !== exp_r.status) begin
            $error("status exp %0h got %0h", exp_r.status, got.status); errors++; end
          if (got.last !== exp_r.last) begin
            $error("last exp %0h got %0h", exp_r.last, got.last); errors++; end
        end
      end
    end
  end

  function automatic logic [31:0] rand_price();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      2: return $urandom_range(3);
      default: return 32'd1000 + $urandom_range(20);
    endcase
  endfunction

  function automatic logic [30:0] rand_amount();
    case ($urandom_range(9))
      0: return 31'($urandom());
      1: return 31'h7FFF_FFFF;
      2: return 31'd0;
      default: return 31'($urandom_range(1, 50));
    endcase
  endfunction

  initial begin
    int i;
    logic [1:0] k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, all kinds, zero amount, book full, partial head
    queue_order(mk_order(KIND_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    queue_order(mk_order(KIND_SELL, 32'h0, 32'h0, 31'h7FFF_FFFE));
    queue_order(mk_order(KIND_SELL, 32'd5, 32'd0, 31'd10));
    queue_order(mk_order(KIND_BUY, 32'd6, 32'd100, 31'd0));
    queue_order(mk_order(KIND_NONE, 32'd7, 32'd7, 31'd7));
    queue_order(mk_order(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    for (i = 0; i < Depth + 1; i++)
      queue_order(mk_order(KIND_SELL, 32'(100 + i), 32'(500 + (i % 4)), 31'd3));
    queue_order(mk_order(KIND_BUY, 32'd200, 32'hFFFF_FFFF, 31'd40));
    queue_order(mk_order(KIND_SELL, 32'd201, 32'd0, 31'd1));
    queue_order(mk_order(KIND_CLEAR, 32'd0, 32'd0, 31'd0));

    // random: mostly crossing orders near one price, some noise
    for (i = 0; i < 254; i++) begin
      case ($urandom_range(39))
        0: k = KIND_CLEAR;
        1: k = KIND_NONE;
        default: k = 2'($urandom_range(1));
      endcase
      queue_order(mk_order(k, $urandom(), rand_price(), rand_amount()));
      if (i == 60) quiet = 1;
      if (i == 120) begin
        quiet = 0;
        hold_sender = 1;
        wait (!in_valid && expected_records.size() == 0);
        hold_sender = 0;
      end
      if (i % 8 == 7) wait (pending_orders.size() < 4);
    end
    wait (pending_orders.size() == 0 && !in_valid);
    wait (expected_records.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_records.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
